// File: sv/usr_pkg.sv
// ----------------------------------------------------------------------------
// usr_pkg
// Shared types and constants of the USB standard request responder.
// ----------------------------------------------------------------------------
package usr_pkg;

    // bRequest codes
    localparam logic [7:0] REQ_GET_STATUS    = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE   = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS   = 8'd5;
    localparam logic [7:0] REQ_GET_DESC      = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIG    = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIG    = 8'd9;

    // bmRequestType values
    localparam logic [7:0] RT_OUT_DEVICE  = 8'h00;
    localparam logic [7:0] RT_IN_DEVICE   = 8'h80;
    localparam logic [7:0] RT_IN_ENDPOINT = 8'h82;

    // descriptor types
    localparam logic [7:0] DT_DEVICE = 8'd1;
    localparam logic [7:0] DT_CONFIG = 8'd2;
    localparam logic [7:0] DT_STRING = 8'd3;

    localparam logic [6:0] ADDR_MASK = 7'h7f;

    // ROM layout
    localparam logic [7:0] OFS_CONFIG = 8'd0;
    localparam logic [7:0] OFS_STR0   = 8'd18;
    localparam logic [7:0] OFS_STR1   = 8'd22;
    localparam logic [7:0] OFS_STR2   = 8'd42;
    localparam logic [7:0] DESC_LEN   = 8'd18;
    localparam logic [4:0] MAX_RUN    = 5'd31;
    localparam int         CONTENT_BYTES = 48;

    // configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_ID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_ID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_REL    = 2'd2;
    localparam logic [15:0] VENDOR_ID_RST  = 16'h0403;
    localparam logic [15:0] PRODUCT_ID_RST = 16'h6001;
    localparam logic [15:0] DEV_REL_RST    = 16'h0400;
    localparam logic [15:0] BCD_USB        = 16'h0110;

    localparam logic [7:0] ROM_CONTENT [CONTENT_BYTES] = '{
        // configuration + interface descriptor
        8'd9, 8'd2, 8'd18, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd10,
        8'd9, 8'd4, 8'd0, 8'd0, 8'd0, 8'hff, 8'hff, 8'hff, 8'd0,
        // string 0: language id
        8'd4, 8'd3, 8'h09, 8'h04,
        // string 1: product name
        8'd20, 8'd3, 8'h73, 8'h00, 8'h69, 8'h00, 8'h6d, 8'h00, 8'h70, 8'h00,
        8'h6c, 8'h00, 8'h65, 8'h00, 8'h75, 8'h00, 8'h73, 8'h00, 8'h62, 8'h00,
        // string 2: serial
        8'd6, 8'd3, 8'h34, 8'h00, 8'h32, 8'h00
    };

    typedef struct packed {
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] setup_value;
        logic [15:0] max_length;
    } t_req;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       last;
        logic       handshake;
        logic [6:0] device_address;
        logic       address_enabled;
        logic [7:0] config_value;
    } t_rsp;

    typedef struct packed {
        logic [15:0] vendor_id;
        logic [15:0] product_id;
        logic [15:0] device_release;
    } t_cfg;

    typedef struct packed {
        logic       re;
        logic [7:0] addr;
    } t_rom_rd;

    function automatic logic [7:0] rom_init(input logic [7:0] a);
        logic [7:0] v;
        v = 8'd0;
        if (a < 8'(CONTENT_BYTES)) begin
            v = ROM_CONTENT[a[5:0]];
        end
        return v;
    endfunction

endpackage

// File: sv/usr_chan_if.sv
// ----------------------------------------------------------------------------
// usr_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface usr_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/usb_standard_request_responder.sv
// ----------------------------------------------------------------------------
// usb_standard_request_responder
// Answers USB standard control requests: one SETUP beat in, a run of
// data-stage beats and one final handshake beat out.
// ----------------------------------------------------------------------------
//
//   port          dir   beat payload
//   i_req         in    request_type, request_code, setup_value, max_length
//   o_rsp         out   data_byte, has_data, last, handshake,
//                       device_address, address_enabled, config_value
//   i_cfg_*       in    register write: vendor_id, product_id, device_release
//
// A data request runs through accept, a length state (ROM read of the first
// byte), n data beats at one per cycle while o_rsp does not stall, and the
// final beat; a descriptor clipped to zero bytes skips the data beats, other
// requests go from accept to the final beat. A ROM fill sweep after reset
// holds i_req.ready low. A stall on o_rsp holds the sequencer; the output
// register lets the next request be taken while the previous final beat waits.
//
module usb_standard_request_responder #(
    parameter int ROM_BYTES    = 64,
    parameter int PACKET_BYTES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    usr_chan_if.sink                      i_req,
    usr_chan_if.source                    o_rsp,
    input  logic                          i_cfg_we,
    input  logic [usr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    import usr_pkg::*;

    t_cfg       r_cfg;
    t_rom_rd    rom_rd;
    logic [7:0] rom_rdata;
    logic       fill_done;

    // configuration registers; an index beyond the list is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vendor_id      <= VENDOR_ID_RST;
            r_cfg.product_id     <= PRODUCT_ID_RST;
            r_cfg.device_release <= DEV_REL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VENDOR_ID:  r_cfg.vendor_id      <= i_cfg_data;
                CFG_PRODUCT_ID: r_cfg.product_id     <= i_cfg_data;
                CFG_DEV_REL:    r_cfg.device_release <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // descriptor memory
    usr_rom #(
        .ROM_BYTES (ROM_BYTES)
    ) u_rom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (rom_rd),
        .o_rdata     (rom_rdata),
        .o_fill_done (fill_done)
    );

    // decode, device state, byte sequencer and output register
    usr_seq #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_fill_done (fill_done),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (i_req.data),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp       (o_rsp.data),
        .o_rd        (rom_rd),
        .i_rdata     (rom_rdata)
    );

endmodule

// File: sv/usr_rom.sv
// ----------------------------------------------------------------------------
// usr_rom
// Descriptor memory: filled by a sweep after reset, registered read.
// ----------------------------------------------------------------------------
module usr_rom #(
    parameter int ROM_BYTES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  usr_pkg::t_rom_rd i_rd,
    output logic [7:0]      o_rdata,
    output logic            o_fill_done
);
    import usr_pkg::*;

    localparam int AW = $clog2(ROM_BYTES);

    logic [7:0]    r_mem [ROM_BYTES];
    logic [AW-1:0] r_fill_idx;
    logic          r_filling;
    logic [7:0]    r_rdata;
    logic          r_hit;
    logic          n_hit;

    assign n_hit = {1'b0, i_rd.addr} < 9'(ROM_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filling  <= 1'b1;
            r_fill_idx <= '0;
        end else if (r_filling) begin
            r_fill_idx <= r_fill_idx + AW'(1);
            if (r_fill_idx == AW'(ROM_BYTES - 1)) begin
                r_filling <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_filling) begin
            r_mem[r_fill_idx] <= rom_init(8'(r_fill_idx));
        end
        if (i_rd.re) begin
            r_rdata <= r_mem[i_rd.addr[AW-1:0]];
            r_hit   <= n_hit;
        end
    end

    assign o_rdata     = r_hit ? r_rdata : 8'd0;
    assign o_fill_done = !r_filling;

endmodule

// File: sv/usr_seq.sv
// ----------------------------------------------------------------------------
// usr_seq
// Request decode, device state and the byte sequencer of the data stage.
// ----------------------------------------------------------------------------
module usr_seq #(
    parameter int PACKET_BYTES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  usr_pkg::t_cfg     i_cfg,
    input  logic              i_fill_done,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  usr_pkg::t_req     i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output usr_pkg::t_rsp     o_rsp,
    output usr_pkg::t_rom_rd  o_rd,
    input  logic [7:0]        i_rdata
);
    import usr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LEN  = 4'b0010,
        S_DATA = 4'b0100,
        S_LAST = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        K_ZERO = 2'd0,
        K_CONF = 2'd1,
        K_DEV  = 2'd2,
        K_ROM  = 2'd3
    } t_kind;

    t_state r_state, n_state;
    logic [6:0] r_address, n_address;
    logic       r_addr_en, n_addr_en;
    logic [7:0] r_config, n_config;
    logic       r_out_valid, n_out_valid;
    t_rsp       r_out, n_out;

    t_kind      r_kind, n_kind;
    logic       r_ok, n_ok;
    logic [7:0] r_base, n_base;
    logic [7:0] r_fixlen, n_fixlen;
    logic       r_rom_len, n_rom_len;
    logic       r_clip, n_clip;
    logic [4:0] r_cap, n_cap;
    logic [4:0] r_len, n_len;
    logic [4:0] r_idx, n_idx;

    logic       slot_free;
    logic       accept;
    logic [7:0] raw_len;
    logic [4:0] run_len;
    logic [7:0] dtype;
    logic [7:0] didx;
    logic [7:0] data_byte;

    function automatic logic [7:0] device_byte(input logic [4:0] i, input t_cfg c);
        logic [7:0] v;
        v = 8'd0;
        case (i)
            5'd0:  v = DESC_LEN;
            5'd1:  v = DT_DEVICE;
            5'd2:  v = BCD_USB[7:0];
            5'd3:  v = BCD_USB[15:8];
            5'd7:  v = 8'(PACKET_BYTES);
            5'd8:  v = c.vendor_id[7:0];
            5'd9:  v = c.vendor_id[15:8];
            5'd10: v = c.product_id[7:0];
            5'd11: v = c.product_id[15:8];
            5'd12: v = c.device_release[7:0];
            5'd13: v = c.device_release[15:8];
            5'd14: v = 8'd1;
            5'd15: v = 8'd2;
            5'd17: v = 8'd1;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    assign slot_free   = !r_out_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE) && i_fill_done;
    assign accept      = o_req_ready && i_req_valid;
    assign dtype       = i_req.setup_value[15:8];
    assign didx        = i_req.setup_value[7:0];

    // run length: descriptor length from ROM or fixed; for descriptors clipped to wLength, capped at MAX_RUN
    assign raw_len = r_rom_len ? i_rdata : r_fixlen;
    always_comb begin
        run_len = raw_len[4:0];
        if (r_clip && ({3'b0, r_cap} < raw_len)) begin
            run_len = r_cap;
        end
    end

    always_comb begin
        case (r_kind)
            K_ZERO:  data_byte = 8'd0;
            K_CONF:  data_byte = r_config;
            K_DEV:   data_byte = device_byte(r_idx, i_cfg);
            default: data_byte = i_rdata;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_address   = r_address;
        n_addr_en   = r_addr_en;
        n_config    = r_config;
        n_out_valid = r_out_valid && !i_rsp_ready;
        n_out       = r_out;
        n_kind      = r_kind;
        n_ok        = r_ok;
        n_base      = r_base;
        n_fixlen    = r_fixlen;
        n_rom_len   = r_rom_len;
        n_clip      = r_clip;
        n_cap       = r_cap;
        n_len       = r_len;
        n_idx       = r_idx;
        o_rd.re     = 1'b0;
        o_rd.addr   = r_base + 8'(r_idx) + 8'd1;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind    = K_ZERO;
                    n_ok      = 1'b0;
                    n_base    = OFS_CONFIG;
                    n_fixlen  = 8'd0;
                    n_rom_len = 1'b0;
                    n_clip    = 1'b0;
                    n_cap     = (i_req.max_length >= 16'(MAX_RUN)) ? MAX_RUN
                                                                   : i_req.max_length[4:0];
                    n_state   = S_LAST;
                    unique case (i_req.request_code) inside
                        REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
                            n_ok = 1'b1;
                        end
                        REQ_GET_STATUS: begin
                            if (i_req.request_type >= RT_IN_DEVICE &&
                                i_req.request_type <= RT_IN_ENDPOINT) begin
                                n_ok     = 1'b1;
                                n_fixlen = 8'd2;
                                n_state  = S_LEN;
                            end
                        end
                        REQ_SET_ADDRESS: begin
                            if (i_req.request_type == RT_OUT_DEVICE) begin
                                n_ok      = 1'b1;
                                n_address = i_req.setup_value[6:0] & ADDR_MASK;
                                n_addr_en = 1'b1;
                            end
                        end
                        REQ_GET_DESC: begin
                            if (i_req.request_type == RT_IN_DEVICE) begin
                                n_clip = 1'b1;
                                if (dtype == DT_DEVICE && didx == 8'd0) begin
                                    n_ok     = 1'b1;
                                    n_kind   = K_DEV;
                                    n_fixlen = DESC_LEN;
                                    n_state  = S_LEN;
                                end else if (dtype == DT_CONFIG && didx == 8'd0) begin
                                    n_ok     = 1'b1;
                                    n_kind   = K_ROM;
                                    n_fixlen = DESC_LEN;
                                    n_state  = S_LEN;
                                end else if (dtype == DT_STRING && didx <= 8'd2) begin
                                    n_ok      = 1'b1;
                                    n_kind    = K_ROM;
                                    n_rom_len = 1'b1;
                                    n_base    = (didx == 8'd0) ? OFS_STR0 :
                                                (didx == 8'd1) ? OFS_STR1 : OFS_STR2;
                                    n_state   = S_LEN;
                                end
                            end
                        end
                        REQ_GET_CONFIG: begin
                            if (i_req.request_type == RT_IN_DEVICE) begin
                                n_ok     = 1'b1;
                                n_kind   = K_CONF;
                                n_fixlen = 8'd1;
                                n_state  = S_LEN;
                            end
                        end
                        REQ_SET_CONFIG: begin
                            if (i_req.request_type == RT_OUT_DEVICE) begin
                                n_ok     = 1'b1;
                                n_config = i_req.setup_value[7:0];
                            end
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                    // fetch the first byte; for strings it is the length
                    o_rd.re   = 1'b1;
                    o_rd.addr = n_base;
                end
            end
            S_LEN: begin
                n_idx = 5'd0;
                n_len = run_len;
                if (run_len == 5'd0) begin
                    n_state = S_LAST;
                end else begin
                    o_rd.re   = 1'b1;
                    o_rd.addr = r_base;
                    n_state   = S_DATA;
                end
            end
            S_DATA: begin
                if (slot_free) begin
                    n_out_valid           = 1'b1;
                    n_out.data_byte       = data_byte;
                    n_out.has_data        = 1'b1;
                    n_out.last            = 1'b0;
                    n_out.handshake       = 1'b0;
                    n_out.device_address  = r_address;
                    n_out.address_enabled = r_addr_en;
                    n_out.config_value    = r_config;
                    if (r_idx == r_len - 5'd1) begin
                        n_state = S_LAST;
                    end else begin
                        n_idx   = r_idx + 5'd1;
                        o_rd.re = 1'b1;
                    end
                end
            end
            S_LAST: begin
                if (slot_free) begin
                    n_out_valid           = 1'b1;
                    n_out.data_byte       = 8'd0;
                    n_out.has_data        = 1'b0;
                    n_out.last            = 1'b1;
                    n_out.handshake       = !r_ok;
                    n_out.device_address  = r_address;
                    n_out.address_enabled = r_addr_en;
                    n_out.config_value    = r_config;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_address   <= 7'd0;
            r_addr_en   <= 1'b0;
            r_config    <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_address   <= n_address;
            r_addr_en   <= n_addr_en;
            r_config    <= n_config;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_kind    <= n_kind;
        r_ok      <= n_ok;
        r_base    <= n_base;
        r_fixlen  <= n_fixlen;
        r_rom_len <= n_rom_len;
        r_clip    <= n_clip;
        r_cap     <= n_cap;
        r_len     <= n_len;
        r_idx     <= n_idx;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule
